// ----- rtl/kps_pkg.sv -----
`timescale 1ns / 1ps

package kps_pkg;

  localparam int KPS_TABLE_DEPTH = 64;
  localparam int FIELD_W         = 6;
  localparam int WORD_W          = 32;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_DIV,
    S_RD_P,
    S_RD_J,
    S_WR_P,
    S_WR_J,
    S_RD,
    S_RD_CAP,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                 operation;
    logic [WORD_W-1:0]   random_word;
    logic [FIELD_W-1:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  entry_value;
    logic [FIELD_W-1:0]  swap_index;
    logic                shuffle_done;
    logic                error_flag;
  } out_t;

endpackage

// ----- rtl/keyed_permutation_shuffle.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                payload
// in        input      in_valid_i / in_ready_o  in_data_i  (in_t)
// out       output     out_valid_o / out_ready_i out_data_o (out_t)
// cfg       input      cfg_we_i                 cfg_data_i (item_count)
//
// start: one table entry written per cycle, over all TABLE_DEPTH entries
// step: one remainder bit per cycle, then two reads, two writes
// read: S_RD then S_RD_CAP; rejected or unused items go straight to S_RESP
// reset clears control state; the table holds nothing until a start fills it
// one item at a time; a result waiting on out_ready_i holds the block in its final state

module keyed_permutation_shuffle
  import kps_pkg::*;
#(
  parameter int TABLE_DEPTH = KPS_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int DW  = AW + 1;
  localparam int BCW = $clog2(WORD_W);

  state_e state_q, state_d;

  logic [CFG_W-1:0]   cfg_q;
  logic [CW-1:0]      count;
  logic [AW-1:0]      pos_q;
  logic               done_q;
  logic [AW-1:0]      fill_q;
  logic [BCW-1:0]     bit_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [WORD_W-1:0]  word_q;
  logic [AW-1:0]      rem_q;
  logic [AW-1:0]      rem_d;
  logic [FIELD_W-1:0] ridx_q;
  logic [FIELD_W-1:0] tmp_q;
  logic [FIELD_W-1:0] res_entry_q;
  logic [FIELD_W-1:0] res_swap_q;
  logic               res_err_q;

  logic [FIELD_W-1:0] mem [TABLE_DEPTH];
  logic [FIELD_W-1:0] rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [FIELD_W-1:0] mem_wdata;

  logic                  in_fire;
  logic                  out_free;
  logic                  step_err;
  logic                  read_err;
  logic [DW-1:0]         trial;
  logic [DW-1:0]         divisor;
  logic [AW+FIELD_W-1:0] rem_pad;
  logic [AW+FIELD_W-1:0] fill_pad;
  logic [AW+FIELD_W-1:0] ridx_pad;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cfg_q == '0) begin
      count = CW'(1);
    end else if (32'(cfg_q) > 32'(TABLE_DEPTH)) begin
      count = CW'(TABLE_DEPTH);
    end else begin
      count = CW'(cfg_q);
    end
  end

  assign step_err    = done_q || (pos_q == '0);
  assign read_err    = 32'(in_data_i.read_index) >= 32'(count);
  assign rem_pad     = {{FIELD_W{1'b0}}, rem_q};
  assign fill_pad    = {{FIELD_W{1'b0}}, fill_q};
  assign ridx_pad    = {{AW{1'b0}}, ridx_q};

  // restoring remainder, one bit per cycle
  assign trial   = {rem_q, word_q[WORD_W-1]};
  assign divisor = {1'b0, pos_q} + DW'(1);
  assign rem_d   = (trial >= divisor) ? AW'(trial - divisor) : AW'(trial);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.operation)
            OP_START: state_d = S_FILL;
            OP_STEP:  state_d = step_err ? S_RESP : S_DIV;
            OP_READ:  state_d = read_err ? S_RESP : S_RD;
            default:  state_d = S_RESP;
          endcase
        end
      end
      S_FILL:   if (fill_q == AW'(TABLE_DEPTH - 1)) state_d = S_RESP;
      S_DIV:    if (bit_q == BCW'(WORD_W - 1)) state_d = S_RD_P;
      S_RD_P:   state_d = S_RD_J;
      S_RD_J:   state_d = S_WR_P;
      S_WR_P:   state_d = S_WR_J;
      S_WR_J:   state_d = S_RESP;
      S_RD:     state_d = S_RD_CAP;
      S_RD_CAP: state_d = S_RESP;
      S_RESP:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = pos_q;
    mem_wdata  = rdata_q;
    mem_raddr  = pos_q;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = fill_pad[FIELD_W-1:0];
      end
      S_RD_P: mem_raddr = pos_q;
      S_RD_J: mem_raddr = rem_q;
      S_WR_P: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = rdata_q;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = rem_q;
        mem_wdata = tmp_q;
      end
      S_RD:   mem_raddr = ridx_pad[AW-1:0];
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      pos_q       <= '0;
      done_q      <= 1'b1;
      fill_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire && in_data_i.operation == OP_START) begin
            pos_q  <= AW'(count - CW'(1));
            done_q <= (count == CW'(1));
            fill_q <= '0;
          end
          bit_q <= '0;
        end
        S_FILL: fill_q <= fill_q + AW'(1);
        S_DIV:  bit_q <= bit_q + BCW'(1);
        S_WR_J: begin
          pos_q <= pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            done_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          word_q      <= in_data_i.random_word;
          ridx_q      <= in_data_i.read_index;
          rem_q       <= '0;
          res_entry_q <= '0;
          res_swap_q  <= '0;
          res_err_q   <= ((in_data_i.operation == OP_STEP) && step_err) ||
                         ((in_data_i.operation == OP_READ) && read_err);
        end
      end
      S_DIV: begin
        rem_q  <= rem_d;
        word_q <= {word_q[WORD_W-2:0], 1'b0};
      end
      S_RD_J:   tmp_q <= rdata_q;
      S_WR_J:   res_swap_q <= rem_pad[FIELD_W-1:0];
      S_RD_CAP: res_entry_q <= rdata_q;
      S_RESP: begin
        if (out_free) begin
          out_q.entry_value  <= res_entry_q;
          out_q.swap_index   <= res_swap_q;
          out_q.shuffle_done <= done_q;
          out_q.error_flag   <= res_err_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
